[rtl/four_lane_lcg_random_range_assert.svh]
// Assertion macros shared by the RTL files of the four-lane random source.
`ifndef FOUR_LANE_LCG_RANDOM_RANGE_ASSERT_SVH
`define FOUR_LANE_LCG_RANDOM_RANGE_ASSERT_SVH
`ifndef SYNTHESIS
`define LCG4_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LCG4_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LCG4_ASSERT(label, clk, rst_n, prop, msg)
`define LCG4_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/lcg4_pkg.sv]
`default_nettype none

package lcg4_pkg;

    localparam int SEED_W      = 32;
    localparam int DRAW_W      = 15;
    localparam int BOUND_W     = 16;
    localparam int VALUE_W     = 16;
    localparam int LANES       = 4;
    localparam int LANE_IDX_W  = 2;
    localparam int POS_W       = 3;
    localparam int CNT_W       = $clog2(DRAW_W + 1);
    localparam int IN_TDATA_W  = 2 * BOUND_W;
    localparam int OUT_TDATA_W = VALUE_W;

    // Bits of the stepped lane value that form one draw.
    localparam int DRAW_LSB = 16;
    localparam int DRAW_MSB = DRAW_LSB + DRAW_W - 1;

    localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(LANES);

    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [LANE_IDX_W-1:0] step_idx;
        logic [LANE_IDX_W-1:0] rd_idx;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [SEED_W-1:0] lane_mult(input logic [LANE_IDX_W-1:0] idx);
        logic [SEED_W-1:0] m;
        unique case (idx)
            2'd0:    m = 32'd214013;
            2'd1:    m = 32'd17405;
            2'd2:    m = 32'd214013;
            default: m = 32'd69069;
        endcase
        return m;
    endfunction

    function automatic logic [SEED_W-1:0] lane_add(input logic [LANE_IDX_W-1:0] idx);
        logic [SEED_W-1:0] a;
        unique case (idx)
            2'd0:    a = 32'd2531011;
            2'd1:    a = 32'd10395331;
            2'd2:    a = 32'd13737667;
            default: a = 32'd1;
        endcase
        return a;
    endfunction

    // Even lanes start one above the seed, odd lanes at the seed itself.
    function automatic logic [SEED_W-1:0] lane_start(input logic [SEED_W-1:0] seed,
                                                     input logic              odd);
        return odd ? seed : seed + SEED_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/four_lane_lcg_random_range.sv]
`default_nettype none

`include "four_lane_lcg_random_range_assert.svh"

// Channel   Direction  Payload
// s_axis    in         tdata = lower_bound, upper_bound; tuser = mode
// m_axis    out        tdata = value; tuser = span_error
// cfg       in         data = seed (reloads the four lanes)
//
// A request served from buffered draws passes through ST_FETCH and ST_FINISH
// before its result is registered. A request that finds the buffer empty first
// passes through ST_STEP, where the lanes step one at a time through a single
// shared 32x32 multiplier. A range reduction adds ST_DIV_WAIT: one start, then
// 15 one-bit steps of a restoring remainder unit, plus its done pulse.
// Reset sets the lanes to 1, 0, 1, 0 and marks the buffer empty; a result that is
// not taken holds the block in its final state until m_axis_tready is high.
module four_lane_lcg_random_range
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [15:0] lower_bound, [31:16] upper_bound
    input  wire logic [lcg4_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]                         s_axis_tuser,

    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [15:0] value
    output logic      [lcg4_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] span_error
    output logic      [0:0]                         m_axis_tuser,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lcg4_pkg::SEED_W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_FETCH,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                                  state_reg, state_next;
    logic                                    mode_reg, mode_next;
    logic [lcg4_pkg::BOUND_W-1:0]            lower_reg, lower_next;
    logic [lcg4_pkg::BOUND_W-1:0]            upper_reg, upper_next;
    logic [lcg4_pkg::BOUND_W-1:0]            span_reg, span_next;
    logic [lcg4_pkg::LANE_IDX_W-1:0]         idx_reg, idx_next;
    logic [lcg4_pkg::POS_W-1:0]              pos_reg, pos_next;
    logic [lcg4_pkg::DRAW_W-1:0]             draw_reg, draw_next;
    logic [lcg4_pkg::VALUE_W-1:0]            res_value_reg, res_value_next;
    logic                                    res_err_reg, res_err_next;
    logic                                    div_start_reg, div_start_next;
    logic                                    out_valid_reg, out_valid_next;
    logic [lcg4_pkg::VALUE_W-1:0]            out_value_reg, out_value_next;
    logic                                    out_err_reg, out_err_next;

    lcg4_pkg::lane_ctrl_t                    lane_ctrl;
    lcg4_pkg::div_status_t                   div_status;
    logic [lcg4_pkg::DRAW_W-1:0]             lane_draw;
    logic [lcg4_pkg::BOUND_W-1:0]            div_rem;
    logic [lcg4_pkg::VALUE_W-1:0]            draw_ext;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_err_reg;

    assign lane_ctrl.load     = cfg_valid;
    assign lane_ctrl.step     = (state_reg == ST_STEP);
    assign lane_ctrl.step_idx = idx_reg;
    assign lane_ctrl.rd_idx   = pos_reg[lcg4_pkg::LANE_IDX_W-1:0];

    assign draw_ext = {{(lcg4_pkg::VALUE_W - lcg4_pkg::DRAW_W){1'b0}}, lane_draw};

    lcg4_lanes u_lanes
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lane_ctrl),
        .seed  (cfg_data),
        .draw  (lane_draw)
    );

    lcg4_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (draw_reg),
        .divisor   (span_reg),
        .status    (div_status),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        span_next      = span_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        draw_next      = draw_reg;
        res_value_next = res_value_reg;
        res_err_next   = res_err_reg;
        div_start_next = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next  = s_axis_tuser[0];
                    lower_next = s_axis_tdata[lcg4_pkg::BOUND_W-1:0];
                    upper_next = s_axis_tdata[2*lcg4_pkg::BOUND_W-1:lcg4_pkg::BOUND_W];
                    idx_next   = '0;
                    state_next = (pos_reg == lcg4_pkg::POS_EMPTY) ? ST_STEP : ST_FETCH;
                end
            end
            ST_STEP:
            begin
                idx_next = idx_reg + lcg4_pkg::LANE_IDX_W'(1);
                if (idx_reg == lcg4_pkg::LANE_IDX_W'(lcg4_pkg::LANES - 1))
                begin
                    pos_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                draw_next    = lane_draw;
                pos_next     = pos_reg + lcg4_pkg::POS_W'(1);
                span_next    = upper_reg - lower_reg;
                res_err_next = 1'b0;
                state_next   = ST_FINISH;
                if (!mode_reg)
                begin
                    res_value_next = draw_ext;
                end
                else if (upper_reg == lower_reg)
                begin
                    res_value_next = '0;
                    res_err_next   = 1'b1;
                end
                else if (upper_reg < lower_reg)
                begin
                    // An inverted range leaves the draw unreduced.
                    res_value_next = draw_ext + lower_reg;
                end
                else
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    res_value_next = div_rem + lower_reg;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pos_reg       <= lcg4_pkg::POS_EMPTY;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        lower_reg     <= lower_next;
        upper_reg     <= upper_next;
        span_reg      <= span_next;
        draw_reg      <= draw_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    `LCG4_ASSERT(a_pos_range, clk, rst_n, pos_reg <= lcg4_pkg::POS_EMPTY, "draw position beyond buffer")
    `LCG4_ASSERT(a_one_item, clk, rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second item taken while busy")
    `LCG4_ASSERT(a_err_zero, clk, rst_n, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == '0, "span error with nonzero value")
    `LCG4_ASSERT_NEVER(a_div_idle_start, clk, rst_n, div_start_reg && div_status.busy, "divider started while busy")

endmodule

`default_nettype wire

[rtl/lcg4_lanes.sv]
`default_nettype none

module lcg4_lanes
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lcg4_pkg::lane_ctrl_t            ctrl,
    input  wire logic [lcg4_pkg::SEED_W-1:0]     seed,
    output logic      [lcg4_pkg::DRAW_W-1:0]     draw
);

    logic [lcg4_pkg::SEED_W-1:0]   lane_reg [lcg4_pkg::LANES];
    logic [lcg4_pkg::DRAW_W-1:0]   buf_reg  [lcg4_pkg::LANES];
    logic [lcg4_pkg::SEED_W-1:0]   lane_cur;
    logic [lcg4_pkg::SEED_W-1:0]   lane_next;

    // One shared multiplier steps the selected lane.
    assign lane_cur  = lane_reg[ctrl.step_idx];
    assign lane_next = lane_cur * lcg4_pkg::lane_mult(ctrl.step_idx)
                     + lcg4_pkg::lane_add(ctrl.step_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcg4_pkg::LANES; i++)
            begin
                lane_reg[i] <= lcg4_pkg::lane_start('0, i[0]);
            end
        end
        else if (ctrl.load)
        begin
            for (int i = 0; i < lcg4_pkg::LANES; i++)
            begin
                lane_reg[i] <= lcg4_pkg::lane_start(seed, i[0]);
            end
        end
        else if (ctrl.step)
        begin
            lane_reg[ctrl.step_idx] <= lane_next;
        end
    end

    // The draw buffer is only read after a refill has written it.
    always_ff @(posedge clk)
    begin
        if (ctrl.step && !ctrl.load)
        begin
            buf_reg[ctrl.step_idx] <= lane_next[lcg4_pkg::DRAW_MSB:lcg4_pkg::DRAW_LSB];
        end
    end

    assign draw = buf_reg[ctrl.rd_idx];

endmodule

`default_nettype wire

[rtl/lcg4_div.sv]
`default_nettype none

`include "four_lane_lcg_random_range_assert.svh"

module lcg4_div
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [lcg4_pkg::DRAW_W-1:0]    dividend,
    input  wire logic [lcg4_pkg::BOUND_W-1:0]   divisor,
    output lcg4_pkg::div_status_t               status,
    output logic      [lcg4_pkg::BOUND_W-1:0]   remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lcg4_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [lcg4_pkg::BOUND_W-1:0]  rem_reg, rem_next;
    logic [lcg4_pkg::DRAW_W-1:0]   dvd_reg, dvd_next;
    logic [lcg4_pkg::BOUND_W-1:0]  divisor_reg, divisor_next;
    logic [lcg4_pkg::BOUND_W:0]    trial;
    logic [lcg4_pkg::BOUND_W:0]    diff;

    // Restoring step: bring down the next dividend bit, subtract if it fits.
    assign trial = {rem_reg, dvd_reg[lcg4_pkg::DRAW_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = lcg4_pkg::CNT_W'(lcg4_pkg::DRAW_W);
            rem_next     = '0;
            dvd_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, divisor_reg}) ? diff[lcg4_pkg::BOUND_W-1:0]
                                                      : trial[lcg4_pkg::BOUND_W-1:0];
            dvd_next = {dvd_reg[lcg4_pkg::DRAW_W-2:0], 1'b0};
            cnt_next = cnt_reg - lcg4_pkg::CNT_W'(1);
            if (cnt_reg == lcg4_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        divisor_reg <= divisor_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

    `LCG4_ASSERT(a_rem_below_divisor, clk, rst_n, done_reg |-> rem_reg < divisor_reg, "remainder not below divisor")
    `LCG4_ASSERT(a_busy_count, clk, rst_n, busy_reg |-> cnt_reg != '0, "busy with an exhausted bit count")
    `LCG4_ASSERT(a_done_pulse, clk, rst_n, done_reg |=> !done_reg, "done held longer than one cycle")

endmodule

`default_nettype wire
